@@ sv/dnv_pkg.sv @@
// Package for the dotted name validator: item types, character codes,
// register indexes and reset values. No dependencies.
package dnv_pkg;

  // Default saturation limit of the name length counter
  localparam int unsigned LENGTH_LIMIT_DEF = 255;

  // Widths fixed by the item fields
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;  // '9'

  // Shortest legal label, also the saturation point of the label counter
  localparam logic [1:0] MIN_LABEL_LEN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 8'd1;

  // Register reset values
  localparam logic [CFG_DAT_W-1:0] MIN_LENGTH_RST = 8'd1;
  localparam logic [CFG_DAT_W-1:0] MAX_LENGTH_RST = 8'd63;

  // One character item
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } char_item_t;

  // Length window from the configuration registers
  typedef struct packed {
    logic [CFG_DAT_W-1:0] min_length;
    logic [CFG_DAT_W-1:0] max_length;
  } len_cfg_t;

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_DIG_0) && (c <= CH_DIG_9);
  endfunction

endpackage

@@ sv/dnv_char_if.sv @@
// Character channel: valid/ready handshake carrying one name character.
// Depends on dnv_pkg.
interface dnv_char_if;
  logic                      valid;
  logic                      ready;
  logic [dnv_pkg::CHAR_W-1:0] character;
  logic                      last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

@@ sv/dnv_result_if.sv @@
// Result channel: valid/ready handshake carrying the name valid bit.
// No dependencies.
interface dnv_result_if;
  logic valid;
  logic ready;
  logic name_valid;

  modport source (output valid, output name_valid, input ready);
  modport sink   (input valid, input name_valid, output ready);
endinterface

@@ sv/dnv_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on dnv_pkg.
interface dnv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dnv_pkg::CFG_IDX_W-1:0] index;
  logic [dnv_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/dnv_in_stage.sv @@
// Input register for character items; loads whenever empty or drained.
// Depends on dnv_pkg.
module dnv_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  input  dnv_pkg::char_item_t src_item,
  output logic                src_ready,
  output logic                q_valid,
  output dnv_pkg::char_item_t q_item,
  input  logic                q_take
);

  // Free when empty or when the held item moves on this cycle
  assign src_ready = !rst && (!q_valid || q_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (src_ready) begin
      q_valid <= src_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      q_item <= src_item;
    end
  end

endmodule

@@ sv/dnv_core.sv @@
// Per-name checking state, label rules and the result register.
// Depends on dnv_pkg.
module dnv_core #(
  parameter int unsigned LENGTH_LIMIT = dnv_pkg::LENGTH_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  dnv_pkg::char_item_t q_item,
  output logic                q_take,
  input  dnv_pkg::len_cfg_t   len_cfg,
  output logic                res_valid,
  output logic                name_valid,
  input  logic                res_ready
);

  // Counter holds up to LENGTH_LIMIT+1
  localparam int unsigned CNT_W = $clog2(LENGTH_LIMIT + 2);
  localparam int unsigned CMP_W = (CNT_W > dnv_pkg::CFG_DAT_W) ? CNT_W : dnv_pkg::CFG_DAT_W;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LENGTH_LIMIT);

  logic [CNT_W-1:0] total_count, total_count_next;
  logic [1:0]       label_count, label_count_next;
  logic             prev_was_hyphen, prev_was_hyphen_next;
  logic             failed, failed_next;
  logic             label_ok;
  logic             ok;
  logic [CMP_W-1:0] total_ext;
  logic [CMP_W-1:0] min_ext;
  logic [CMP_W-1:0] max_ext;
  logic [dnv_pkg::CHAR_W-1:0] c;

  assign c = q_item.character;

  // Item moves on unless a final character finds the result register full
  assign q_take = q_valid && (!q_item.last_char || !res_valid || res_ready);

  assign label_ok = (label_count >= dnv_pkg::MIN_LABEL_LEN) && !prev_was_hyphen;

  // Next state for one character
  always_comb begin
    total_count_next     = (total_count <= LIMIT) ? total_count + 1'b1 : total_count;
    label_count_next     = label_count;
    prev_was_hyphen_next = prev_was_hyphen;
    failed_next          = failed;
    if (c == dnv_pkg::CH_DOT) begin
      if (!label_ok) failed_next = 1'b1;
      label_count_next     = 2'd0;
      prev_was_hyphen_next = 1'b0;
    end else begin
      if (label_count == 2'd0) begin
        if (!dnv_pkg::is_lower(c)) failed_next = 1'b1;
      end else if (!dnv_pkg::is_lower(c) && !dnv_pkg::is_digit(c) &&
                   c != dnv_pkg::CH_HYPHEN) begin
        failed_next = 1'b1;
      end
      if (label_count < dnv_pkg::MIN_LABEL_LEN) label_count_next = label_count + 1'b1;
      prev_was_hyphen_next = (c == dnv_pkg::CH_HYPHEN);
    end
  end

  // Whole-name verdict on the final character
  assign total_ext = CMP_W'(total_count_next);
  assign min_ext   = CMP_W'(len_cfg.min_length);
  assign max_ext   = CMP_W'(len_cfg.max_length);
  assign ok = !failed_next
           && (label_count_next >= dnv_pkg::MIN_LABEL_LEN) && !prev_was_hyphen_next
           && (total_count_next <= LIMIT)
           && (total_ext >= min_ext)
           && (total_ext <= max_ext);

  // Name state, cleared after each final character
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count     <= '0;
      label_count     <= 2'd0;
      prev_was_hyphen <= 1'b0;
      failed          <= 1'b0;
    end else if (q_take) begin
      if (q_item.last_char) begin
        total_count     <= '0;
        label_count     <= 2'd0;
        prev_was_hyphen <= 1'b0;
        failed          <= 1'b0;
      end else begin
        total_count     <= total_count_next;
        label_count     <= label_count_next;
        prev_was_hyphen <= prev_was_hyphen_next;
        failed          <= failed_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_take && q_item.last_char) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.last_char) begin
      name_valid <= ok;
    end
  end

endmodule

@@ sv/dotted_name_validator_top.sv @@
// Dotted name validator: one character item per cycle, one result per name.
// A final character goes through the input register and then the result register.
// Throughput: 1 character per cycle; the input register and result register
// stall only while a result waits and a further final character is pending.
// Reset (rst, synchronous): clears all name state and results, restores
// min_length to 1 and max_length to 63. Depends on dnv_pkg and the channel interfaces.
module dotted_name_validator_top #(
  parameter int unsigned LENGTH_LIMIT = dnv_pkg::LENGTH_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  dnv_char_if.sink        char_in,
  dnv_result_if.source    result_out,
  dnv_cfg_if.sink         cfg
);

  dnv_pkg::char_item_t src_item;
  dnv_pkg::char_item_t q_item;
  dnv_pkg::len_cfg_t   len_cfg;
  logic                q_valid;
  logic                q_take;

  assign src_item.character = char_in.character;
  assign src_item.last_char = char_in.last_char;

  // Configuration registers, always ready; unknown indexes dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg.min_length <= dnv_pkg::MIN_LENGTH_RST;
      len_cfg.max_length <= dnv_pkg::MAX_LENGTH_RST;
    end else if (cfg.valid) begin
      if (cfg.index == dnv_pkg::REG_MIN_LENGTH) len_cfg.min_length <= cfg.data;
      if (cfg.index == dnv_pkg::REG_MAX_LENGTH) len_cfg.max_length <= cfg.data;
    end
  end

  dnv_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .src_valid (char_in.valid),
    .src_item  (src_item),
    .src_ready (char_in.ready),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  dnv_core #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take),
    .len_cfg    (len_cfg),
    .res_valid  (result_out.valid),
    .name_valid (result_out.name_valid),
    .res_ready  (result_out.ready)
  );

endmodule

@@ sv/dnv_port_checker.sv @@
// Port-level checks for the dotted name validator, bound to the top level.
// Sees only the top-level ports; no package dependency.
module dnv_port_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_name_valid
);

  // A waiting result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_name_valid))
    else $error("result changed while stalled");

  // Input stalls only behind a blocked result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A fresh result follows an accepted final character
  assert property (@(posedge clk) disable iff (rst || $past(rst) || $past(rst, 2))
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a final character");

endmodule

bind dotted_name_validator_top dnv_port_checker u_port_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (char_in.valid),
  .in_ready       (char_in.ready),
  .in_last        (char_in.last_char),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .out_name_valid (result_out.name_valid)
);

@@ test/testbench.sv @@
// Testbench for dotted_name_validator_top: drives names one character per item,
// predicts the per-name verdict and checks every result against it.
// Depends on dnv_pkg and the char, result and config channel interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CH_W          = dnv_pkg::CHAR_W;
  localparam int unsigned IDX_W         = dnv_pkg::CFG_IDX_W;
  localparam int unsigned DAT_W         = dnv_pkg::CFG_DAT_W;
  localparam int unsigned NAME_LIMIT    = dnv_pkg::LENGTH_LIMIT_DEF;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_CHARS   = 30;
  localparam int unsigned STEADY_CHARS  = 100;

  logic clk = 1'b0;
  logic rst;

  dnv_char_if   char_ch ();
  dnv_result_if res_ch ();
  dnv_cfg_if    cfg_ch ();

  dotted_name_validator_top #(
    .LENGTH_LIMIT(NAME_LIMIT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_ch),
    .result_out(res_ch),
    .cfg       (cfg_ch)
  );

  always #10 clk = ~clk;

  // Predictor state: one name in progress plus the length window
  logic [8:0]       name_len;
  logic [1:0]       label_len;
  bit               ends_hyphen;
  bit               broken;
  logic [DAT_W-1:0] win_min = dnv_pkg::MIN_LENGTH_RST;
  logic [DAT_W-1:0] win_max = dnv_pkg::MAX_LENGTH_RST;

  bit              pending_verdicts[$];
  logic [CH_W-1:0] name_buf[$];

  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned chars_sent = 0;
  int unsigned names_sent = 0;
  int unsigned names_valid = 0;
  int unsigned results_seen = 0;
  int unsigned windows_used = 0;

  // Advance the name state by one character; returns 1 when a verdict is due
  function automatic bit step_name(input logic [CH_W-1:0] c, input bit last,
                                   output bit verdict);
    bit lower_ch;
    bit digit_ch;
    lower_ch = (c >= dnv_pkg::CH_LOW_A) && (c <= dnv_pkg::CH_LOW_Z);
    digit_ch = (c >= dnv_pkg::CH_DIG_0) && (c <= dnv_pkg::CH_DIG_9);
    verdict  = 1'b0;
    if (name_len <= NAME_LIMIT) name_len = name_len + 9'd1;
    if (c == dnv_pkg::CH_DOT) begin
      // a dot closes the label, which must be long enough and not end in '-'
      if (label_len < dnv_pkg::MIN_LABEL_LEN || ends_hyphen) broken = 1'b1;
      label_len   = 2'd0;
      ends_hyphen = 1'b0;
    end else begin
      if (label_len == 2'd0) begin
        if (!lower_ch) broken = 1'b1;
      end else if (!lower_ch && !digit_ch && c != dnv_pkg::CH_HYPHEN) begin
        broken = 1'b1;
      end
      if (label_len < dnv_pkg::MIN_LABEL_LEN) label_len = label_len + 2'd1;
      ends_hyphen = (c == dnv_pkg::CH_HYPHEN);
    end
    if (!last) return 1'b0;
    verdict = !broken && label_len >= dnv_pkg::MIN_LABEL_LEN && !ends_hyphen
              && name_len <= NAME_LIMIT && name_len >= win_min && name_len <= win_max;
    name_len    = '0;
    label_len   = '0;
    ends_hyphen = 1'b0;
    broken      = 1'b0;
    return 1'b1;
  endfunction

  // Cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result ready with random stall bursts
  always @(posedge clk) begin
    if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 8);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest pending verdict
  always @(posedge clk) begin
    bit want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen <= results_seen + 1;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual name_valid %0b",
                 $time, res_ch.name_valid);
        error_count <= error_count + 1;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.name_valid !== want) begin
          $display("%0t: name_valid mismatch, expected %0b, actual %0b",
                   $time, want, res_ch.name_valid);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Send one character item, with an optional idle burst ahead of it
  task automatic send_char(input logic [CH_W-1:0] c, input bit last);
    bit due;
    bit verdict;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.character <= c;
    char_ch.last_char <= last;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
    due = step_name(c, last, verdict);
    if (due) begin
      pending_verdicts.push_back(verdict);
      names_sent++;
      if (verdict) names_valid++;
    end
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++)
      send_char(name_buf[i], i == name_buf.size() - 1);
    name_buf.delete();
  endtask

  // Stop sending and wait until every verdict has come back
  task automatic drain();
    char_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DAT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == dnv_pkg::REG_MIN_LENGTH) win_min = value;
    else if (idx == dnv_pkg::REG_MAX_LENGTH) win_max = value;
  endtask

  // Program the length window; optionally also hit an unmapped index
  task automatic set_window(input logic [DAT_W-1:0] lo, input logic [DAT_W-1:0] hi,
                            input bit stray);
    if (stray) write_reg(dnv_pkg::REG_MAX_LENGTH + IDX_W'($urandom_range(1, 254)),
                         DAT_W'($urandom));
    write_reg(dnv_pkg::REG_MIN_LENGTH, lo);
    write_reg(dnv_pkg::REG_MAX_LENGTH, hi);
    cfg_ch.valid <= 1'b0;
    windows_used++;
  endtask

  function automatic logic [CH_W-1:0] rand_lower();
    return dnv_pkg::CH_LOW_A + CH_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CH_W-1:0] rand_digit();
    return dnv_pkg::CH_DIG_0 + CH_W'($urandom_range(0, 9));
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // Well-formed label: lowercase first, letter or digit last, '-' allowed inside
  task automatic add_label(input int len);
    name_buf.push_back(rand_lower());
    for (int k = 1; k < len - 1; k++) begin
      case ($urandom_range(0, 5))
        0:       name_buf.push_back(dnv_pkg::CH_HYPHEN);
        1:       name_buf.push_back(rand_digit());
        default: name_buf.push_back(rand_lower());
      endcase
    end
    if (len >= 2) name_buf.push_back($urandom_range(0, 2) == 0 ? rand_digit() : rand_lower());
  endtask

  task automatic build_good(input int labels, input int shortest, input int longest);
    for (int i = 0; i < labels; i++) begin
      if (i > 0) name_buf.push_back(dnv_pkg::CH_DOT);
      add_label($urandom_range(shortest, longest));
    end
  endtask

  // Well-formed name of an exact total length (labels short only below 3)
  task automatic build_exact(input int total);
    int rest;
    int len;
    rest = total;
    while (rest > 40) begin
      len = $urandom_range(3, 30);
      add_label(len);
      name_buf.push_back(dnv_pkg::CH_DOT);
      rest -= len + 1;
    end
    add_label(rest);
  endtask

  // Break a well-formed name in one of several ways
  task automatic corrupt_name();
    int pos;
    int keep;
    pos = $urandom_range(0, name_buf.size() - 1);
    case ($urandom_range(0, 7))
      0: name_buf[pos] = CH_W'($urandom_range(0, 255));
      1: name_buf[pos] = dnv_pkg::CH_LOW_A - 8'h20 + CH_W'($urandom_range(0, 25));
      2: name_buf[pos] = dnv_pkg::CH_DOT;
      3: name_buf.push_front(dnv_pkg::CH_DOT);
      4: name_buf.push_back(dnv_pkg::CH_DOT);
      5: name_buf.push_back(dnv_pkg::CH_HYPHEN);
      6: name_buf[0] = rand_digit();
      default: begin
        keep = $urandom_range(1, name_buf.size());
        while (name_buf.size() > keep) void'(name_buf.pop_back());
      end
    endcase
  endtask

  task automatic send_random_name();
    int pick;
    int target;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      build_good($urandom_range(1, 4), 3, 10);
    end else if (pick < 75) begin
      build_good($urandom_range(1, 4), 2, 10);
      corrupt_name();
    end else if (pick < 85) begin
      // noise: arbitrary bytes
      n = $urandom_range(1, 12);
      repeat (n) name_buf.push_back(CH_W'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      // lengths right around the window edges
      case ($urandom_range(0, 3))
        0:       target = int'(win_min) - 1;
        1:       target = int'(win_min);
        2:       target = int'(win_max);
        default: target = int'(win_max) + 1;
      endcase
      if (target < 1) target = 1;
      build_exact(target);
    end else begin
      build_exact($urandom_range(200, 300));
    end
    send_name();
  endtask

  // Label rules under the reset window
  task automatic test_label_rules();
    push_text("a-9");      send_name();  // hyphen and digit inside a label
    push_text("ab");       send_name();  // label too short
    push_text("9ab");      send_name();  // digit first
    push_text("ab-");      send_name();  // hyphen last
    push_text(".abc");     send_name();  // leading dot
    push_text("abc.");     send_name();  // trailing dot
    push_text("abc..def"); send_name();  // doubled dot
    push_text("aBc");      send_name();  // uppercase
    name_buf.push_back(dnv_pkg::CH_LOW_A);  // byte above ASCII
    name_buf.push_back(8'hFF);
    name_buf.push_back(dnv_pkg::CH_LOW_Z);
    send_name();
    name_buf.push_back(8'h00);           // single null byte
    send_name();
    push_text("zz9");      send_name();
    drain();
  endtask

  // Length window edges, counter saturation and ignored register indexes
  task automatic test_length_limits();
    build_exact(dnv_pkg::MAX_LENGTH_RST);      send_name();
    build_exact(dnv_pkg::MAX_LENGTH_RST + 1);  send_name();
    drain();
    set_window(8'd0, 8'd255, 1'b1);
    build_exact(256); send_name();
    build_exact(515); send_name();    // would wrap a 9-bit count to a legal length
    drain();
    set_window(8'd255, 8'd255, 1'b1);
    build_exact(255); send_name();
    build_exact(254); send_name();
    drain();
    set_window(8'd10, 8'd5, 1'b0);    // empty window
    build_exact(7); send_name();
    drain();
    set_window(8'd7, 8'd7, 1'b0);
    build_exact(7); send_name();
    build_exact(8); send_name();
    drain();
  endtask

  // Random names over a series of length windows, idling on and off
  task automatic test_random_traffic();
    int unsigned start;
    logic [DAT_W-1:0] lo;
    logic [DAT_W-1:0] hi;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lo = dnv_pkg::MIN_LENGTH_RST; hi = dnv_pkg::MAX_LENGTH_RST; end
        1: begin lo = 8'd0;   hi = 8'd255; end
        2: begin lo = 8'd255; hi = 8'd255; end
        3: begin lo = 8'd200; hi = 8'd100; end
        4: begin lo = 8'd3;   hi = 8'd3;   end
        default: begin
          lo = DAT_W'($urandom_range(0, 40));
          hi = ($urandom_range(0, 3) == 0) ? DAT_W'($urandom_range(1, 255))
                                           : DAT_W'($urandom_range(lo, 255));
        end
      endcase
      set_window(lo, hi, $urandom_range(0, 2) == 0);
      idle_on = (phase % 3 != 2);
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_name();
      drain();
    end
  endtask

  // Closing stretch at full rate with no idling on either side
  task automatic test_back_to_back();
    int unsigned start;
    idle_on = 1'b0;
    set_window(dnv_pkg::MIN_LENGTH_RST, dnv_pkg::MAX_LENGTH_RST, 1'b0);
    start = chars_sent;
    while (chars_sent - start < STEADY_CHARS) send_random_name();
    drain();
  endtask

  initial begin
    name_len          = '0;
    label_len         = '0;
    ends_hyphen       = 1'b0;
    broken            = 1'b0;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.character = '0;
    char_ch.last_char = 1'b0;
    res_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_label_rules();
    test_length_limits();
    test_random_traffic();
    test_back_to_back();

    $display("Sent %0d characters as %0d names, %0d predicted valid, over %0d windows.",
             chars_sent, names_sent, names_valid, windows_used);
    $display("Checked %0d results, %0d mismatches.", results_seen, error_count);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
